// ----- rtl/pcq_pkg.sv -----
// ----------------------------------------------------------------------------
// pcq_pkg: shared types and constants of the pointer click qualifier
// Holds the register map, reset values, result codes and the structs that
// travel between the pipeline stages.
// ----------------------------------------------------------------------------
package pcq_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CLICKS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_WINDOW_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MULTI_WINDOW_MS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MULTI_RADIUS      = 3'd5;

    // Register reset values.
    localparam logic [15:0] FRAME_WIDTH_RST     = 16'd640;
    localparam logic [15:0] FRAME_HEIGHT_RST    = 16'd480;
    localparam logic [3:0]  MAX_CLICKS_RST      = 4'd8;
    localparam logic [15:0] RATE_WINDOW_RST     = 16'd1000;
    localparam logic [15:0] MULTI_WINDOW_RST    = 16'd500;
    localparam logic [7:0]  MULTI_RADIUS_RST    = 8'd5;

    // Result kinds and the multi-click ceiling.
    localparam logic       KIND_CLICK = 1'b0;
    localparam logic       KIND_MOVE  = 1'b1;
    localparam logic [1:0] COUNT_CAP  = 2'd3;
    localparam logic [1:0] COUNT_NONE = 2'd0;
    localparam logic [1:0] COUNT_ONE  = 2'd1;

    // Default depth of the result queue; it must hold at least two entries.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [3:0]  max_clicks;
        logic [15:0] rate_window_ms;
        logic [15:0] multi_window_ms;
        logic [7:0]  multi_radius;
    } cfg_t;

    // One registered poll tick after conversion to frame coordinates.
    typedef struct packed {
        logic        link_ready;
        logic        app_active;
        logic        down;
        logic        in_frame;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [31:0] now_ms;
    } tick_t;

    typedef struct packed {
        logic        event_kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [1:0]  click_count;
        logic        last;
    } result_t;

endpackage

// ----- rtl/pcq_intf.sv -----
// ----------------------------------------------------------------------------
// pcq_intf: channel interfaces of the pointer click qualifier
// Valid/ready channels for poll ticks and for click and move results.
// ----------------------------------------------------------------------------
interface pcq_tick_if;
    logic        valid;
    logic        ready;
    logic        link_ready;
    logic        app_active;
    logic [15:0] pointer_v;
    logic [15:0] pointer_h;
    logic [7:0]  button_byte;
    logic [15:0] view_left;
    logic [15:0] view_top;
    logic [31:0] now_ms;

    modport source (
        output valid, link_ready, app_active, pointer_v, pointer_h, button_byte,
               view_left, view_top, now_ms,
        input  ready
    );
    modport sink (
        input  valid, link_ready, app_active, pointer_v, pointer_h, button_byte,
               view_left, view_top, now_ms,
        output ready
    );
endinterface

interface pcq_result_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [1:0]  click_count;
    logic        last;

    modport source (
        output valid, event_kind, pos_x, pos_y, click_count, last,
        input  ready
    );
    modport sink (
        input  valid, event_kind, pos_x, pos_y, click_count, last,
        output ready
    );
endinterface

// ----- rtl/pcq_front.sv -----
// ----------------------------------------------------------------------------
// pcq_front: input register and frame coordinate conversion
// Captures one tick per transaction and presents it in frame coordinates.
// ----------------------------------------------------------------------------
module pcq_front (
    input  logic             clk,
    input  logic             rst_n,
    pcq_tick_if.sink         tick,
    input  pcq_pkg::cfg_t    cfg,
    input  logic             take,
    output logic             valid,
    output pcq_pkg::tick_t   tk
);

    logic        valid_reg;
    logic        link_reg;
    logic        active_reg;
    logic [15:0] pv_reg;
    logic [15:0] ph_reg;
    logic [7:0]  button_reg;
    logic [15:0] vl_reg;
    logic [15:0] vt_reg;
    logic [31:0] now_reg;

    logic        accept;
    logic [16:0] px;
    logic [16:0] py;
    logic        in_frame;

    assign tick.ready = !valid_reg || take;
    assign accept     = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            link_reg   <= tick.link_ready;
            active_reg <= tick.app_active;
            pv_reg     <= tick.pointer_v;
            ph_reg     <= tick.pointer_h;
            button_reg <= tick.button_byte;
            vl_reg     <= tick.view_left;
            vt_reg     <= tick.view_top;
            now_reg    <= tick.now_ms;
        end
    end

    // Differences of two signed 16-bit values fit in 17 bits exactly.
    assign px = {ph_reg[15], ph_reg} - {vl_reg[15], vl_reg};
    assign py = {pv_reg[15], pv_reg} - {vt_reg[15], vt_reg};

    assign in_frame = !px[16] && (px[15:0] < cfg.frame_width) &&
                      !py[16] && (py[15:0] < cfg.frame_height);

    always_comb
    begin
        tk.link_ready = link_reg;
        tk.app_active = active_reg;
        tk.down       = (button_reg == 8'h00);
        tk.in_frame   = in_frame;
        tk.pos_x      = in_frame ? px[15:0] : 16'd0;
        tk.pos_y      = in_frame ? py[15:0] : 16'd0;
        tk.now_ms     = now_reg;
    end

    assign valid = valid_reg;

endmodule

// ----- rtl/pcq_track.sv -----
// ----------------------------------------------------------------------------
// pcq_track: click and move tracking state
// Holds the button history, the rate window and the prior click and move,
// and forms up to two results for each tick it consumes.
// ----------------------------------------------------------------------------
module pcq_track (
    input  logic               clk,
    input  logic               rst_n,
    input  pcq_pkg::cfg_t      cfg,
    input  logic               go,
    input  pcq_pkg::tick_t     tk,
    output logic [1:0]         push_n,
    output pcq_pkg::result_t   push0,
    output pcq_pkg::result_t   push1
);

    logic        prev_down_reg,   prev_down_next;
    logic [31:0] win_start_reg,   win_start_next;
    logic [3:0]  win_clicks_reg,  win_clicks_next;
    logic        click_seen_reg,  click_seen_next;
    logic [31:0] click_ms_reg,    click_ms_next;
    logic [15:0] click_x_reg,     click_x_next;
    logic [15:0] click_y_reg,     click_y_next;
    logic [1:0]  multi_reg,       multi_next;
    logic        move_seen_reg,   move_seen_next;
    logic [15:0] move_x_reg,      move_x_next;
    logic [15:0] move_y_reg,      move_y_next;

    logic        live;
    logic        press;
    logic        restart;
    logic [3:0]  clicks_eff;
    logic        click_fire;
    logic        move_fire;
    logic [16:0] dx;
    logic [16:0] dy;
    logic [15:0] adx;
    logic [15:0] ady;
    logic [15:0] sq_x;
    logic [15:0] sq_y;
    logic [16:0] dist_sq;
    logic [15:0] radius_sq;
    logic        near;
    logic        soon;
    logic [1:0]  count_new;
    pcq_pkg::result_t click_res;
    pcq_pkg::result_t move_res;

    assign live  = tk.link_ready && tk.app_active;
    assign press = live && tk.in_frame && tk.down && !prev_down_reg;

    // Rate window: elapsed time wraps at 32 bits.
    assign restart    = (tk.now_ms - win_start_reg) >= {16'd0, cfg.rate_window_ms};
    assign clicks_eff = restart ? 4'd0 : win_clicks_reg;
    assign click_fire = press && (clicks_eff < cfg.max_clicks);

    // Distance test: a box check first lets the squares use only the low 8 bits
    // of each distance, since the radius never exceeds 255.
    assign dx  = {1'b0, tk.pos_x} - {1'b0, click_x_reg};
    assign dy  = {1'b0, tk.pos_y} - {1'b0, click_y_reg};
    assign adx = dx[16] ? 16'(-dx) : dx[15:0];
    assign ady = dy[16] ? 16'(-dy) : dy[15:0];
    assign sq_x      = adx[7:0] * adx[7:0];
    assign sq_y      = ady[7:0] * ady[7:0];
    assign dist_sq   = {1'b0, sq_x} + {1'b0, sq_y};
    assign radius_sq = cfg.multi_radius * cfg.multi_radius;

    assign near = click_seen_reg &&
                  (adx <= {8'd0, cfg.multi_radius}) &&
                  (ady <= {8'd0, cfg.multi_radius}) &&
                  (dist_sq <= {1'b0, radius_sq});
    assign soon = click_seen_reg &&
                  ((tk.now_ms - click_ms_reg) < {16'd0, cfg.multi_window_ms});

    assign count_new = (near && soon && (multi_reg < pcq_pkg::COUNT_CAP)) ?
                       multi_reg + 2'd1 : pcq_pkg::COUNT_ONE;

    assign move_fire = live && tk.in_frame &&
                       (!move_seen_reg || (tk.pos_x != move_x_reg) ||
                        (tk.pos_y != move_y_reg));

    always_comb
    begin
        prev_down_next  = prev_down_reg;
        win_start_next  = win_start_reg;
        win_clicks_next = win_clicks_reg;
        click_seen_next = click_seen_reg;
        click_ms_next   = click_ms_reg;
        click_x_next    = click_x_reg;
        click_y_next    = click_y_reg;
        multi_next      = multi_reg;
        move_seen_next  = move_seen_reg;
        move_x_next     = move_x_reg;
        move_y_next     = move_y_reg;

        if (go && tk.link_ready)
        begin
            prev_down_next = tk.app_active && tk.down;
        end
        if (go && press)
        begin
            if (restart)
            begin
                win_start_next = tk.now_ms;
            end
            win_clicks_next = clicks_eff;
        end
        if (go && click_fire)
        begin
            win_clicks_next = clicks_eff + 4'd1;
            click_seen_next = 1'b1;
            click_ms_next   = tk.now_ms;
            click_x_next    = tk.pos_x;
            click_y_next    = tk.pos_y;
            multi_next      = count_new;
        end
        if (go && move_fire)
        begin
            move_seen_next = 1'b1;
            move_x_next    = tk.pos_x;
            move_y_next    = tk.pos_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_down_reg  <= 1'b0;
            win_start_reg  <= 32'd0;
            win_clicks_reg <= 4'd0;
            click_seen_reg <= 1'b0;
            click_ms_reg   <= 32'd0;
            click_x_reg    <= 16'd0;
            click_y_reg    <= 16'd0;
            multi_reg      <= 2'd0;
            move_seen_reg  <= 1'b0;
            move_x_reg     <= 16'd0;
            move_y_reg     <= 16'd0;
        end
        else
        begin
            prev_down_reg  <= prev_down_next;
            win_start_reg  <= win_start_next;
            win_clicks_reg <= win_clicks_next;
            click_seen_reg <= click_seen_next;
            click_ms_reg   <= click_ms_next;
            click_x_reg    <= click_x_next;
            click_y_reg    <= click_y_next;
            multi_reg      <= multi_next;
            move_seen_reg  <= move_seen_next;
            move_x_reg     <= move_x_next;
            move_y_reg     <= move_y_next;
        end
    end

    always_comb
    begin
        click_res.event_kind  = pcq_pkg::KIND_CLICK;
        click_res.pos_x       = tk.pos_x;
        click_res.pos_y       = tk.pos_y;
        click_res.click_count = count_new;
        click_res.last        = !move_fire;

        move_res.event_kind  = pcq_pkg::KIND_MOVE;
        move_res.pos_x       = tk.pos_x;
        move_res.pos_y       = tk.pos_y;
        move_res.click_count = pcq_pkg::COUNT_NONE;
        move_res.last        = 1'b1;

        // A click always goes ahead of a move from the same tick.
        push0  = click_fire ? click_res : move_res;
        push1  = move_res;
        push_n = 2'd0;
        if (go)
        begin
            push_n = {1'b0, click_fire} + {1'b0, move_fire};
        end
    end

endmodule

// ----- rtl/pcq_outq.sv -----
// ----------------------------------------------------------------------------
// pcq_outq: result queue
// A small register queue that takes up to two results a cycle and hands one
// result per transaction to the output channel.
// ----------------------------------------------------------------------------
module pcq_outq #(
    parameter int DEPTH = pcq_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         push_n,
    input  pcq_pkg::result_t   push0,
    input  pcq_pkg::result_t   push1,
    output logic               has_room,
    pcq_result_if.source       result
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    pcq_pkg::result_t  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wptr_inc;
    logic              pop;
    pcq_pkg::result_t  head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_IDX) ? '0 : p + PTR_W'(1);
    endfunction

    assign wptr_inc = ptr_inc(wptr_reg);
    assign pop      = result.valid && result.ready;
    assign has_room = (count_reg <= ROOM_MAX);

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = pop ? ptr_inc(rptr_reg) : rptr_reg;
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);
        if (push_n == 2'd1)
        begin
            wptr_next = wptr_inc;
        end
        else if (push_n == 2'd2)
        begin
            wptr_next = ptr_inc(wptr_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            slot_reg[wptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            slot_reg[wptr_inc] <= push1;
        end
    end

    assign head = slot_reg[rptr_reg];

    assign result.valid       = (count_reg != '0);
    assign result.event_kind  = head.event_kind;
    assign result.pos_x       = head.pos_x;
    assign result.pos_y       = head.pos_y;
    assign result.click_count = head.click_count;
    assign result.last        = head.last;

endmodule

// ----- rtl/pointer_click_qualifier_core.sv -----
// ----------------------------------------------------------------------------
// pointer_click_qualifier_core: polled pointer click and move qualifier
// Turns pointer poll ticks into click results with a multi-click count and
// into move results, with per-window click rate limiting.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake     | Carries
//  ---------+-----------+---------------+-------------------------------------
//  tick     | in        | valid / ready | one poll tick per transaction
//  result   | out       | valid / ready | one click or move result
//  cfg      | in        | cfg_we only   | register write, index and data
//
//  A tick is captured in the input register, converted and qualified
//  combinationally from it while the queue has room for two results, and
//  its results are then written into the result queue, whose registered
//  count makes the first result visible on the result channel.
//  Ticks are accepted back to back as long as the queue has room for two
//  results; a tick giving two results occupies the output channel for both
//  transactions, so the sustained tick rate is set by the single output port.
//  Reset clears all tracking state and loads the register defaults.
//  A stalled result channel fills the queue and then stops tick acceptance.
//
module pointer_click_qualifier_core #(
    parameter int QUEUE_DEPTH = pcq_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pcq_tick_if.sink                        tick,
    pcq_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [pcq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pcq_pkg::cfg_t    cfg_reg;
    pcq_pkg::tick_t   tk;
    pcq_pkg::result_t push0;
    pcq_pkg::result_t push1;
    logic [1:0]       push_n;
    logic             front_valid;
    logic             has_room;
    logic             go;

    // Configuration registers. Writes are expected only while the block is
    // idle, so that no tick in flight sees a half-updated setting. Unknown
    // indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width     <= pcq_pkg::FRAME_WIDTH_RST;
            cfg_reg.frame_height    <= pcq_pkg::FRAME_HEIGHT_RST;
            cfg_reg.max_clicks      <= pcq_pkg::MAX_CLICKS_RST;
            cfg_reg.rate_window_ms  <= pcq_pkg::RATE_WINDOW_RST;
            cfg_reg.multi_window_ms <= pcq_pkg::MULTI_WINDOW_RST;
            cfg_reg.multi_radius    <= pcq_pkg::MULTI_RADIUS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcq_pkg::REG_FRAME_WIDTH:     cfg_reg.frame_width     <= cfg_data;
                pcq_pkg::REG_FRAME_HEIGHT:    cfg_reg.frame_height    <= cfg_data;
                pcq_pkg::REG_MAX_CLICKS:      cfg_reg.max_clicks      <= cfg_data[3:0];
                pcq_pkg::REG_RATE_WINDOW_MS:  cfg_reg.rate_window_ms  <= cfg_data;
                pcq_pkg::REG_MULTI_WINDOW_MS: cfg_reg.multi_window_ms <= cfg_data;
                pcq_pkg::REG_MULTI_RADIUS:    cfg_reg.multi_radius    <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // The registered tick moves into the tracking stage only when the queue
    // can absorb the worst case of two results.
    assign go = front_valid && has_room;

    pcq_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick),
        .cfg   (cfg_reg),
        .take  (go),
        .valid (front_valid),
        .tk    (tk)
    );

    pcq_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .go     (go),
        .tk     (tk),
        .push_n (push_n),
        .push0  (push0),
        .push1  (push1)
    );

    pcq_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_n   (push_n),
        .push0    (push0),
        .push1    (push1),
        .has_room (has_room),
        .result   (result)
    );

endmodule
